// ----- design/irps_pkg.sv -----
// Shared constants and codes for the IR pulse train sequencer.
// Used by the channel interfaces and by the top level; depends on nothing.
package irps_pkg;

   localparam int MARK_W      = 10;
   localparam int PAUSE_W     = 11;
   localparam int MAX_W       = 16;
   localparam int WORD_W      = 16;
   localparam int LEN_W       = 16;
   localparam int PAUSE_OUT_W = 20;
   localparam int POS_W       = 5;
   localparam int RC_W        = 3;
   localparam int FACTOR_W    = 4;
   localparam int COUNT_W     = 5;
   localparam int BIT_IDX_W   = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Frame layout: start pair, sixteen data pairs, stop pair.
   localparam logic [POS_W-1:0]   LAST_POS      = 5'd17;
   localparam logic [POS_W-1:0]   DATA_BITS     = 5'd16;
   localparam logic [LEN_W-1:0]   PAIRS_PER_MSG = 16'd18;
   localparam logic [RC_W:0]      REPEAT_TOTAL  = 4'd5;
   localparam logic [RC_W:0]      SINGLE_TOTAL  = 4'd1;

   // Repeat spacing factors.
   localparam logic [FACTOR_W-1:0] EARLY_FACTOR = 4'd5;
   localparam logic [FACTOR_W-1:0] LATE_BASE    = 4'd8;
   localparam int                  CHAN_LSB     = 12;

   // Commands.
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MARK_TIME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_PAUSE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_PAUSE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MSG    = 3'd5;

   // Register reset values.
   localparam logic [MARK_W-1:0]  MARK_RST  = 10'd158;
   localparam logic [PAUSE_W-1:0] LOW_RST   = 11'd263;
   localparam logic [PAUSE_W-1:0] HIGH_RST  = 11'd553;
   localparam logic [PAUSE_W-1:0] START_RST = 11'd1026;
   localparam logic [PAUSE_W-1:0] STOP_RST  = 11'd1026;
   localparam logic [MAX_W-1:0]   MAX_RST   = 16'd16000;

   typedef logic [MARK_W-1:0]      mark_type;
   typedef logic [PAUSE_W-1:0]     pause_type;
   typedef logic [PAUSE_OUT_W-1:0] pause_out_type;
   typedef logic [WORD_W-1:0]      word_type;

endpackage

// ----- design/irps_if.sv -----
// Valid/ready channel interfaces for the IR pulse train sequencer.
// Depends on irps_pkg for payload types and widths.
interface irps_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   irps_pkg::word_type                  data_word;
   logic                                repeat_flag;

   modport source (output valid, cmd, data_word, repeat_flag, input ready);
   modport sink   (input valid, cmd, data_word, repeat_flag, output ready);
endinterface

interface irps_rsp_if;
   logic                                valid;
   logic                                ready;
   irps_pkg::mark_type                  mark_us;
   irps_pkg::pause_out_type             pause_us;
   logic [irps_pkg::RC_W-1:0]           repeat_index;
   logic                                last;

   modport source (output valid, mark_us, pause_us, repeat_index, last, input ready);
   modport sink   (input valid, mark_us, pause_us, repeat_index, last, output ready);
endinterface

// ----- design/ir_pulse_train_sequencer.sv -----
// IR pulse train sequencer: turns a 16-bit word into start, data and stop mark/pause pairs.
// Depends on irps_pkg and on the channel interfaces in irps_if.sv.
// A pair appears on the result channel in the cycle after its command transfer.
// Throughput: one command per cycle unless the output stalls; the result register frees in the same cycle it is taken.
// The single result register sets the rate; an advance while idle gives no result.
// Reset (synchronous, active high) empties the result register, leaves the block idle
// and restores the timing registers to their default values.
module ir_pulse_train_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   irps_req_if.sink                              req_chan,
   irps_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [irps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [irps_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Timing registers.
   irps_pkg::mark_type              mark_time_ff;
   irps_pkg::pause_type             low_pause_ff, high_pause_ff, start_pause_ff, stop_pause_ff;
   logic [irps_pkg::MAX_W-1:0]      max_msg_ff;

   // Train state.
   irps_pkg::word_type              held_word_ff, held_word_in;
   logic                            held_repeat_ff, held_repeat_in;
   logic [irps_pkg::POS_W-1:0]      bit_position_ff, bit_position_in;
   logic [irps_pkg::RC_W-1:0]       repeat_counter_ff, repeat_counter_in;
   logic [irps_pkg::LEN_W-1:0]      message_length_ff, message_length_in;
   logic                            busy_ff, busy_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   irps_pkg::mark_type              mark_us_ff;
   irps_pkg::pause_out_type         pause_us_ff, pause_us_in;
   logic [irps_pkg::RC_W-1:0]       repeat_index_ff;
   logic                            last_ff, last_in;

   logic                            accept;
   logic                            emit;
   logic [irps_pkg::COUNT_W-1:0]    ones;
   logic [irps_pkg::LEN_W-1:0]      length_calc;
   logic [irps_pkg::BIT_IDX_W-1:0]  bit_idx;
   logic [irps_pkg::FACTOR_W-1:0]   factor;
   logic                            padded;
   logic [irps_pkg::PAUSE_OUT_W-1:0] pad_total;
   logic [irps_pkg::PAUSE_OUT_W-1:0] stop_calc;
   logic [irps_pkg::RC_W:0]         needed;
   logic [irps_pkg::RC_W-1:0]       channel_code;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Message length from the ones count of the word, modulo 2^16.
   assign ones = irps_pkg::COUNT_W'($countones(req_chan.data_word));
   assign length_calc =
      irps_pkg::LEN_W'({6'd0, mark_time_ff} * irps_pkg::PAIRS_PER_MSG)
      + irps_pkg::LEN_W'({11'd0, ones} * {5'd0, high_pause_ff})
      + irps_pkg::LEN_W'({11'd0, irps_pkg::DATA_BITS - ones} * {5'd0, low_pause_ff})
      + {5'd0, start_pause_ff} + {5'd0, stop_pause_ff};

   // Repeat spacing for the stop pair, taken from the held train state.
   assign channel_code = {1'b0, held_word_ff[irps_pkg::CHAN_LSB+1:irps_pkg::CHAN_LSB]};
   always_comb begin
      padded = held_repeat_ff;
      factor = irps_pkg::EARLY_FACTOR;
      case (repeat_counter_in) inside
         [3'd0:3'd1]: factor = irps_pkg::EARLY_FACTOR;
         [3'd2:3'd3]: factor = irps_pkg::LATE_BASE + irps_pkg::FACTOR_W'({channel_code, 1'b0});
         default:     padded = 1'b0;
      endcase
   end

   assign pad_total = irps_pkg::PAUSE_OUT_W'({16'd0, factor} * {4'd0, max_msg_ff})
                      + {9'd0, stop_pause_ff};

   always_comb begin
      if (!padded) begin
         stop_calc = {9'd0, stop_pause_ff};
      end else if (pad_total < {4'd0, message_length_ff}) begin
         // A negative pad saturates to zero.
         stop_calc = '0;
      end else begin
         stop_calc = pad_total - {4'd0, message_length_ff};
      end
   end

   always_comb begin
      held_word_in      = held_word_ff;
      held_repeat_in    = held_repeat_ff;
      bit_position_in   = bit_position_ff;
      repeat_counter_in = repeat_counter_ff;
      message_length_in = message_length_ff;
      busy_in           = busy_ff;
      emit              = 1'b0;
      if (accept) begin
         if (req_chan.cmd == irps_pkg::CMD_LOAD) begin
            held_word_in      = req_chan.data_word;
            held_repeat_in    = req_chan.repeat_flag;
            bit_position_in   = '0;
            repeat_counter_in = '0;
            message_length_in = length_calc;
            busy_in           = 1'b1;
            emit              = 1'b1;
         end else if (busy_ff) begin
            emit = 1'b1;
            if (bit_position_ff == irps_pkg::LAST_POS) begin
               bit_position_in   = '0;
               repeat_counter_in = repeat_counter_ff + 3'd1;
            end else begin
               bit_position_in = bit_position_ff + 5'd1;
            end
         end
      end

      needed  = held_repeat_in ? irps_pkg::REPEAT_TOTAL : irps_pkg::SINGLE_TOTAL;
      last_in = (bit_position_in == irps_pkg::LAST_POS)
                && (({1'b0, repeat_counter_in} + 4'd1) >= needed);
      if (emit && last_in) begin
         busy_in = 1'b0;
      end
   end

   // Data bits go out most significant first.
   assign bit_idx = irps_pkg::BIT_IDX_W'(irps_pkg::DATA_BITS - bit_position_in);

   always_comb begin
      if (bit_position_in == '0) begin
         pause_us_in = {9'd0, start_pause_ff};
      end else if (bit_position_in == irps_pkg::LAST_POS) begin
         pause_us_in = stop_calc;
      end else if (held_word_ff[bit_idx]) begin
         pause_us_in = {9'd0, high_pause_ff};
      end else begin
         pause_us_in = {9'd0, low_pause_ff};
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_time_ff      <= irps_pkg::MARK_RST;
         low_pause_ff      <= irps_pkg::LOW_RST;
         high_pause_ff     <= irps_pkg::HIGH_RST;
         start_pause_ff    <= irps_pkg::START_RST;
         stop_pause_ff     <= irps_pkg::STOP_RST;
         max_msg_ff        <= irps_pkg::MAX_RST;
         held_word_ff      <= '0;
         held_repeat_ff    <= 1'b0;
         bit_position_ff   <= '0;
         repeat_counter_ff <= '0;
         message_length_ff <= '0;
         busy_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         held_word_ff      <= held_word_in;
         held_repeat_ff    <= held_repeat_in;
         bit_position_ff   <= bit_position_in;
         repeat_counter_ff <= repeat_counter_in;
         message_length_ff <= message_length_in;
         busy_ff           <= busy_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               irps_pkg::REG_MARK_TIME:  mark_time_ff   <= csr_wdata[irps_pkg::MARK_W-1:0];
               irps_pkg::REG_LOW_PAUSE:  low_pause_ff   <= csr_wdata[irps_pkg::PAUSE_W-1:0];
               irps_pkg::REG_HIGH_PAUSE: high_pause_ff  <= csr_wdata[irps_pkg::PAUSE_W-1:0];
               irps_pkg::REG_START:      start_pause_ff <= csr_wdata[irps_pkg::PAUSE_W-1:0];
               irps_pkg::REG_STOP:       stop_pause_ff  <= csr_wdata[irps_pkg::PAUSE_W-1:0];
               irps_pkg::REG_MAX_MSG:    max_msg_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         mark_us_ff      <= mark_time_ff;
         pause_us_ff     <= pause_us_in;
         repeat_index_ff <= repeat_counter_in;
         last_ff         <= last_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mark_us      = mark_us_ff;
   assign rsp_chan.pause_us     = pause_us_ff;
   assign rsp_chan.repeat_index = repeat_index_ff;
   assign rsp_chan.last         = last_ff;

`ifndef SYNTH
   // The frame position and transmission count stay inside the train.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_position_ff <= irps_pkg::LAST_POS)
      else $error("bit position beyond the stop pair");

   a_rc_range: assert property (@(posedge clock) disable iff (reset)
      repeat_counter_ff < irps_pkg::RC_W'(irps_pkg::REPEAT_TOTAL))
      else $error("repeat counter beyond the fifth transmission");

   // An advance transfer while idle must not produce a result.
   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.cmd == irps_pkg::CMD_ADVANCE && !busy_ff |=> !rsp_valid_ff)
      else $error("result produced by an advance while idle");

   // A load always starts a train with the start pair of transmission zero.
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.cmd == irps_pkg::CMD_LOAD
      |=> rsp_valid_ff && busy_ff && repeat_index_ff == '0 && !last_ff)
      else $error("load did not start a new train");
`endif

endmodule
